// ===== sv/edp_pkg.sv =====
// shared types, codes and constants of the es descriptor parser
package edp_pkg;

    localparam int unsigned SizeWidth = 28;
    localparam int unsigned CountWidth = 3;
    localparam logic [5:0] AudioStreamType = 6'h05;
    localparam logic [SizeWidth-1:0] CfgFieldsBytes = SizeWidth'(13);
    localparam logic [CountWidth-1:0] SizeGroupsMax = CountWidth'(4);

    typedef enum logic [4:0] {
        PH_OUTER_TAG   = 5'd0,
        PH_OUTER_SIZE  = 5'd1,
        PH_ESID        = 5'd2,
        PH_FLAGS       = 5'd3,
        PH_DEP_ID      = 5'd4,
        PH_OCR_ID      = 5'd5,
        PH_CFG_TAG     = 5'd6,
        PH_CFG_SIZE    = 5'd7,
        PH_OBJ_TYPE    = 5'd8,
        PH_STREAM_TYPE = 5'd9,
        PH_BUF_SIZE    = 5'd10,
        PH_MAX_BR      = 5'd11,
        PH_AVG_BR      = 5'd12,
        PH_INFO_TAG    = 5'd13,
        PH_INFO_SIZE   = 5'd14,
        PH_INFO_DATA   = 5'd15
    } phase_t;

    typedef enum logic [2:0] {
        KIND_ES_ID       = 3'd0,
        KIND_OBJECT_TYPE = 3'd1,
        KIND_BUFFER_SIZE = 3'd2,
        KIND_MAX_BITRATE = 3'd3,
        KIND_AVG_BITRATE = 3'd4,
        KIND_INFO_BYTE   = 3'd5,
        KIND_STATUS      = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_ES_TAG   = 3'd1,
        ST_URL          = 3'd2,
        ST_BAD_CFG_TAG  = 3'd3,
        ST_NOT_AUDIO    = 3'd4,
        ST_BAD_INFO_TAG = 3'd5,
        ST_TRUNC        = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        REG_ES_TAG     = 2'd0,
        REG_CONFIG_TAG = 2'd1,
        REG_INFO_TAG   = 2'd2
    } reg_index_t;

    typedef struct packed {
        phase_t                 phase;
        logic [CountWidth-1:0]  field_cnt;
        logic [31:0]            field_acc;
        logic [SizeWidth-1:0]   size_acc;
        logic [CountWidth-1:0]  size_cnt;
        logic [1:0]             opt_flags;
        logic [SizeWidth-1:0]   cfg_size;
        logic [SizeWidth-1:0]   info_left;
        logic                   finished;
    } parse_state_t;

    typedef struct packed {
        logic [7:0] es_tag;
        logic [7:0] config_tag;
        logic [7:0] info_tag;
    } tags_t;

    typedef struct packed {
        logic        have;
        kind_t       kind;
        logic [31:0] value;
        status_t     status;
        logic        done;
    } result_t;

    localparam parse_state_t ParseClear = '{
        phase:     PH_OUTER_TAG,
        field_cnt: '0,
        field_acc: '0,
        size_acc:  '0,
        size_cnt:  '0,
        opt_flags: '0,
        cfg_size:  '0,
        info_left: '0,
        finished:  1'b0
    };

endpackage

// ===== sv/edp_step.sv =====
// next parse state and result for one descriptor byte
module edp_step
    import edp_pkg::*;
(
    input  parse_state_t cur,
    input  tags_t        tags,
    input  logic [7:0]   data_byte,
    input  logic         last,
    output parse_state_t nxt,
    output result_t      res
);

    logic [SizeWidth-1:0]  size_shift;
    logic [CountWidth-1:0] size_inc;
    logic                  size_end;
    logic [31:0]           field_shift;
    logic [CountWidth-1:0] field_inc;
    logic [1:0]            flags_new;
    logic [SizeWidth-1:0]  info_dec;

    // shared accumulator arithmetic
    always_comb
    begin
        size_shift  = {cur.size_acc[SizeWidth-8:0], data_byte[6:0]};
        size_inc    = cur.size_cnt + CountWidth'(1);
        size_end    = !data_byte[7] || (size_inc >= SizeGroupsMax);
        field_shift = {cur.field_acc[23:0], data_byte};
        field_inc   = cur.field_cnt + CountWidth'(1);
        flags_new   = {data_byte[7], data_byte[5]};
        info_dec    = cur.info_left - SizeWidth'(1);
    end

    // per phase decode
    always_comb
    begin
        nxt = cur;
        res = '{have: 1'b0, kind: KIND_STATUS, value: '0, status: ST_OK, done: 1'b0};

        if (!cur.finished)
        begin
            case (cur.phase)
                PH_OUTER_TAG:
                begin
                    if (data_byte != tags.es_tag)
                    begin
                        res.have   = 1'b1;
                        res.done   = 1'b1;
                        res.status = ST_BAD_ES_TAG;
                    end
                    else
                    begin
                        nxt.phase    = PH_OUTER_SIZE;
                        nxt.size_acc = '0;
                        nxt.size_cnt = '0;
                    end
                end
                PH_OUTER_SIZE:
                begin
                    nxt.size_acc = size_shift;
                    nxt.size_cnt = size_end ? '0 : size_inc;
                    if (size_end)
                    begin
                        nxt.phase     = PH_ESID;
                        nxt.field_acc = '0;
                    end
                end
                PH_ESID:
                begin
                    nxt.field_acc = field_shift;
                    nxt.field_cnt = field_inc;
                    if (field_inc >= CountWidth'(2))
                    begin
                        nxt.field_cnt = '0;
                        nxt.phase     = PH_FLAGS;
                        res.have      = 1'b1;
                        res.kind      = KIND_ES_ID;
                        res.value     = {16'h0000, field_shift[15:0]};
                    end
                end
                PH_FLAGS:
                begin
                    if (data_byte[6])
                    begin
                        res.have   = 1'b1;
                        res.done   = 1'b1;
                        res.status = ST_URL;
                    end
                    else
                    begin
                        nxt.opt_flags = flags_new;
                        if (flags_new[1])
                            nxt.phase = PH_DEP_ID;
                        else if (flags_new[0])
                            nxt.phase = PH_OCR_ID;
                        else
                            nxt.phase = PH_CFG_TAG;
                    end
                end
                PH_DEP_ID:
                begin
                    nxt.field_acc = field_shift;
                    nxt.field_cnt = field_inc;
                    if (field_inc >= CountWidth'(2))
                    begin
                        nxt.field_cnt = '0;
                        nxt.opt_flags = {1'b0, cur.opt_flags[0]};
                        nxt.phase     = cur.opt_flags[0] ? PH_OCR_ID : PH_CFG_TAG;
                    end
                end
                PH_OCR_ID:
                begin
                    nxt.field_acc = field_shift;
                    nxt.field_cnt = field_inc;
                    if (field_inc >= CountWidth'(2))
                    begin
                        nxt.field_cnt = '0;
                        nxt.opt_flags = '0;
                        nxt.phase     = PH_CFG_TAG;
                    end
                end
                PH_CFG_TAG:
                begin
                    if (data_byte != tags.config_tag)
                    begin
                        res.have   = 1'b1;
                        res.done   = 1'b1;
                        res.status = ST_BAD_CFG_TAG;
                    end
                    else
                    begin
                        nxt.phase    = PH_CFG_SIZE;
                        nxt.size_acc = '0;
                        nxt.size_cnt = '0;
                    end
                end
                PH_CFG_SIZE:
                begin
                    nxt.size_acc = size_shift;
                    nxt.size_cnt = size_end ? '0 : size_inc;
                    if (size_end)
                    begin
                        nxt.cfg_size = size_shift;
                        nxt.phase    = PH_OBJ_TYPE;
                    end
                end
                PH_OBJ_TYPE:
                begin
                    res.have  = 1'b1;
                    res.kind  = KIND_OBJECT_TYPE;
                    res.value = {24'h000000, data_byte};
                    nxt.phase = PH_STREAM_TYPE;
                end
                PH_STREAM_TYPE:
                begin
                    if (data_byte[7:2] != AudioStreamType)
                    begin
                        res.have   = 1'b1;
                        res.done   = 1'b1;
                        res.status = ST_NOT_AUDIO;
                    end
                    else
                    begin
                        nxt.phase     = PH_BUF_SIZE;
                        nxt.field_acc = '0;
                        nxt.field_cnt = '0;
                    end
                end
                PH_BUF_SIZE:
                begin
                    nxt.field_acc = field_shift;
                    nxt.field_cnt = field_inc;
                    if (field_inc >= CountWidth'(3))
                    begin
                        nxt.field_cnt = '0;
                        nxt.field_acc = '0;
                        nxt.phase     = PH_MAX_BR;
                        res.have      = 1'b1;
                        res.kind      = KIND_BUFFER_SIZE;
                        res.value     = {8'h00, field_shift[23:0]};
                    end
                end
                PH_MAX_BR:
                begin
                    nxt.field_acc = field_shift;
                    nxt.field_cnt = field_inc;
                    if (field_inc >= CountWidth'(4))
                    begin
                        nxt.field_cnt = '0;
                        nxt.field_acc = '0;
                        nxt.phase     = PH_AVG_BR;
                        res.have      = 1'b1;
                        res.kind      = KIND_MAX_BITRATE;
                        res.value     = field_shift;
                    end
                end
                PH_AVG_BR:
                begin
                    nxt.field_acc = field_shift;
                    nxt.field_cnt = field_inc;
                    if (field_inc >= CountWidth'(4))
                    begin
                        nxt.field_cnt = '0;
                        res.have      = 1'b1;
                        res.kind      = KIND_AVG_BITRATE;
                        res.value     = field_shift;
                        if (cur.cfg_size > CfgFieldsBytes)
                            nxt.phase = PH_INFO_TAG;
                        else
                            res.done = 1'b1;
                    end
                end
                PH_INFO_TAG:
                begin
                    if (data_byte != tags.info_tag)
                    begin
                        res.have   = 1'b1;
                        res.done   = 1'b1;
                        res.status = ST_BAD_INFO_TAG;
                    end
                    else
                    begin
                        nxt.phase    = PH_INFO_SIZE;
                        nxt.size_acc = '0;
                        nxt.size_cnt = '0;
                    end
                end
                PH_INFO_SIZE:
                begin
                    nxt.size_acc = size_shift;
                    nxt.size_cnt = size_end ? '0 : size_inc;
                    if (size_end)
                    begin
                        nxt.info_left = size_shift;
                        if (size_shift == '0)
                        begin
                            // empty payload ends the parse with a plain ok
                            res.have = 1'b1;
                            res.done = 1'b1;
                        end
                        else
                            nxt.phase = PH_INFO_DATA;
                    end
                end
                PH_INFO_DATA:
                begin
                    res.have      = 1'b1;
                    res.kind      = KIND_INFO_BYTE;
                    res.value     = {24'h000000, data_byte};
                    nxt.info_left = info_dec;
                    if (info_dec == '0)
                        res.done = 1'b1;
                end
                default:
                begin
                    nxt = cur;
                end
            endcase

            // input ran out before the parse completed
            if (!res.done && last)
            begin
                res.have   = 1'b1;
                res.done   = 1'b1;
                res.kind   = KIND_STATUS;
                res.value  = '0;
                res.status = ST_TRUNC;
            end

            if (res.done)
                nxt.finished = 1'b1;
        end

        // a final byte always returns the parse to the start
        if (last)
            nxt = ParseClear;
    end

endmodule

// ===== sv/es_descriptor_parser.sv =====
// es descriptor parser top level: tag registers, parse state and result register
// result: registered, and on the output in the cycle after its byte's transaction
// throughput: one byte per cycle; in_ready drops only while a result waits
//   and out_ready is low, since the single result register is the only buffer
// reset: rst_n clears the parse state and the result valid and sets the tags
//   to 3, 4 and 5; no clearing pass is needed
module es_descriptor_parser
    import edp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  field_kind,
    output logic [31:0] value,
    output logic [2:0]  status,
    output logic        done_res
);

    tags_t        tags_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      res_next;
    logic         in_acc;
    logic         out_valid_reg;
    kind_t        kind_reg;
    logic [31:0]  value_reg;
    status_t      status_reg;
    logic         done_reg;

    // tag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tags_reg <= '{es_tag: 8'd3, config_tag: 8'd4, info_tag: 8'd5};
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_ES_TAG:     tags_reg.es_tag     <= cfg_data;
                REG_CONFIG_TAG: tags_reg.config_tag <= cfg_data;
                REG_INFO_TAG:   tags_reg.info_tag   <= cfg_data;
                default:        tags_reg            <= tags_reg;
            endcase
        end
    end

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign in_acc   = in_valid && in_ready;

    // byte decode
    edp_step u_step (
        .cur       (state_reg),
        .tags      (tags_reg),
        .data_byte (data_byte),
        .last      (last),
        .nxt       (state_next),
        .res       (res_next)
    );

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ParseClear;
        else if (in_acc)
            state_reg <= state_next;
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_acc)
            out_valid_reg <= res_next.have;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (in_acc && res_next.have)
        begin
            kind_reg   <= res_next.kind;
            value_reg  <= res_next.value;
            status_reg <= res_next.status;
            done_reg   <= res_next.done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign field_kind = kind_reg;
    assign value      = value_reg;
    assign status     = status_reg;
    assign done_res   = done_reg;

    // an error code only travels in a status-only transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == ST_OK || kind_reg == KIND_STATUS))
        else $error("error status on a field transaction");

    // status-only transactions carry a zero value and are final
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_STATUS) |-> (value_reg == '0 && done_reg))
        else $error("status-only transaction with value or not final");

    // a final byte returns the parse to the start
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && last) |=> (state_reg.phase == PH_OUTER_TAG && !state_reg.finished))
        else $error("parse not cleared after final byte");

    // bytes other than a final one after a finished parse give no result and keep it finished
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && state_reg.finished && !last) |=> (state_reg.finished && !out_valid_reg))
        else $error("byte after finished parse produced a result");

endmodule

// ===== tb/sv/edp_field_check.sv =====
// field checker of the es descriptor parser: byte predictor and result compare
module edp_field_check
    import edp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  field_kind,
    input  logic [31:0] value,
    input  logic [2:0]  status,
    input  logic        done_res,
    output int          fail_count,
    output int          waiting
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] EsTagReset = 8'd3;
    localparam logic [7:0] ConfigTagReset = 8'd4;
    localparam logic [7:0] InfoTagReset = 8'd5;
    localparam int unsigned ReportLimit = 10;

    // predicted parse state and tag registers
    parse_state_t st;
    tags_t        tags;

    result_t expected_fields[$];
    int          field_errors = 0;

    // one 7-bit size group; returns 1 when the size is complete
    function automatic logic add_size_group(input logic [7:0] b);
        st.size_acc = {st.size_acc[SizeWidth-8:0], b[6:0]};
        st.size_cnt = st.size_cnt + 1'b1;
        if (!b[7] || st.size_cnt >= SizeGroupsMax) begin
            st.size_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // one byte of an n-byte big-endian field; returns 1 when complete
    function automatic logic add_field_byte(input logic [7:0] b, input int unsigned n);
        st.field_acc = {st.field_acc[23:0], b};
        st.field_cnt = st.field_cnt + 1'b1;
        if (st.field_cnt >= n) begin
            st.field_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // next phase once the flags or one optional id are consumed
    function automatic void skip_optional_ids();
        if (st.opt_flags[1])
            st.phase = PH_DEP_ID;
        else if (st.opt_flags[0])
            st.phase = PH_OCR_ID;
        else
            st.phase = PH_CFG_TAG;
    endfunction

    // expected result of one accepted byte, advances the predicted state
    function automatic result_t predict_field(input logic [7:0] b, input logic is_last);
        result_t r;
        r = '0;
        r.kind = KIND_STATUS;
        r.status = ST_OK;
        if (st.finished) begin
            if (is_last)
                st = ParseClear;
            return r;
        end
        case (st.phase)
            PH_OUTER_TAG:
                if (b != tags.es_tag) begin
                    r.have = 1'b1;
                    r.done = 1'b1;
                    r.status = ST_BAD_ES_TAG;
                end
                else begin
                    st.phase = PH_OUTER_SIZE;
                    st.size_acc = '0;
                    st.size_cnt = '0;
                end
            PH_OUTER_SIZE:
                if (add_size_group(b)) begin
                    st.phase = PH_ESID;
                    st.field_acc = '0;
                end
            PH_ESID:
                if (add_field_byte(b, 2)) begin
                    r.have = 1'b1;
                    r.kind = KIND_ES_ID;
                    r.value = {16'h0, st.field_acc[15:0]};
                    st.phase = PH_FLAGS;
                end
            PH_FLAGS:
                if (b[6]) begin
                    r.have = 1'b1;
                    r.done = 1'b1;
                    r.status = ST_URL;
                end
                else begin
                    st.opt_flags = {b[7], b[5]};
                    skip_optional_ids();
                end
            PH_DEP_ID:
                if (add_field_byte(b, 2)) begin
                    st.opt_flags[1] = 1'b0;
                    skip_optional_ids();
                end
            PH_OCR_ID:
                if (add_field_byte(b, 2)) begin
                    st.opt_flags = '0;
                    st.phase = PH_CFG_TAG;
                end
            PH_CFG_TAG:
                if (b != tags.config_tag) begin
                    r.have = 1'b1;
                    r.done = 1'b1;
                    r.status = ST_BAD_CFG_TAG;
                end
                else begin
                    st.phase = PH_CFG_SIZE;
                    st.size_acc = '0;
                    st.size_cnt = '0;
                end
            PH_CFG_SIZE:
                if (add_size_group(b)) begin
                    st.cfg_size = st.size_acc;
                    st.phase = PH_OBJ_TYPE;
                end
            PH_OBJ_TYPE:
            begin
                r.have = 1'b1;
                r.kind = KIND_OBJECT_TYPE;
                r.value = {24'h0, b};
                st.phase = PH_STREAM_TYPE;
            end
            PH_STREAM_TYPE:
                if (b[7:2] != AudioStreamType) begin
                    r.have = 1'b1;
                    r.done = 1'b1;
                    r.status = ST_NOT_AUDIO;
                end
                else begin
                    st.phase = PH_BUF_SIZE;
                    st.field_acc = '0;
                    st.field_cnt = '0;
                end
            PH_BUF_SIZE:
                if (add_field_byte(b, 3)) begin
                    r.have = 1'b1;
                    r.kind = KIND_BUFFER_SIZE;
                    r.value = {8'h0, st.field_acc[23:0]};
                    st.phase = PH_MAX_BR;
                    st.field_acc = '0;
                end
            PH_MAX_BR:
                if (add_field_byte(b, 4)) begin
                    r.have = 1'b1;
                    r.kind = KIND_MAX_BITRATE;
                    r.value = st.field_acc;
                    st.phase = PH_AVG_BR;
                    st.field_acc = '0;
                end
            PH_AVG_BR:
                if (add_field_byte(b, 4)) begin
                    r.have = 1'b1;
                    r.kind = KIND_AVG_BITRATE;
                    r.value = st.field_acc;
                    if (st.cfg_size > CfgFieldsBytes)
                        st.phase = PH_INFO_TAG;
                    else
                        r.done = 1'b1;
                end
            PH_INFO_TAG:
                if (b != tags.info_tag) begin
                    r.have = 1'b1;
                    r.done = 1'b1;
                    r.status = ST_BAD_INFO_TAG;
                end
                else begin
                    st.phase = PH_INFO_SIZE;
                    st.size_acc = '0;
                    st.size_cnt = '0;
                end
            PH_INFO_SIZE:
                if (add_size_group(b)) begin
                    st.info_left = st.size_acc;
                    // empty payload ends the parse with a plain ok
                    if (st.info_left == '0) begin
                        r.have = 1'b1;
                        r.done = 1'b1;
                    end
                    else
                        st.phase = PH_INFO_DATA;
                end
            default:
            begin
                r.have = 1'b1;
                r.kind = KIND_INFO_BYTE;
                r.value = {24'h0, b};
                st.info_left = st.info_left - 1'b1;
                if (st.info_left == '0)
                    r.done = 1'b1;
            end
        endcase
        // buffer ended before the parse did
        if (!r.done && is_last) begin
            r.have = 1'b1;
            r.done = 1'b1;
            r.kind = KIND_STATUS;
            r.status = ST_TRUNC;
        end
        if (r.done) begin
            if (is_last)
                st = ParseClear;
            else
                st.finished = 1'b1;
        end
        if (r.kind == KIND_STATUS)
            r.value = '0;
        return r;
    endfunction

    function automatic void note_failure(input string what, input result_t want,
                                         input result_t got);
        field_errors++;
        if (field_errors <= ReportLimit) begin
            $display("%0t %s: expected kind %0d value %h status %0d done %0b",
                     $realtime, what, want.kind, want.value, want.status, want.done);
            $display("    got kind %0d value %h status %0d done %0b",
                     got.kind, got.value, got.status, got.done);
        end
    endfunction

    // compare output transactions, then predict from input transactions
    always @(posedge clk or negedge rst_n) begin : watch
        result_t got;
        result_t want;
        result_t pred;
        if (!rst_n) begin
            st = ParseClear;
            tags.es_tag = EsTagReset;
            tags.config_tag = ConfigTagReset;
            tags.info_tag = InfoTagReset;
            expected_fields.delete();
            waiting <= 0;
            fail_count <= field_errors;
        end
        else begin
            if (out_valid && out_ready) begin
                got.have = 1'b1;
                got.kind = kind_t'(field_kind);
                got.value = value;
                got.status = status_t'(status);
                got.done = done_res;
                if (expected_fields.size() == 0)
                    note_failure("unexpected transaction", '0, got);
                else begin
                    want = expected_fields.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value ||
                        got.status !== want.status || got.done !== want.done)
                        note_failure("field mismatch", want, got);
                end
            end
            if (in_valid && in_ready) begin
                pred = predict_field(data_byte, last);
                if (pred.have)
                    expected_fields = {expected_fields, pred};
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_ES_TAG:     tags.es_tag = cfg_data;
                    REG_CONFIG_TAG: tags.config_tag = cfg_data;
                    REG_INFO_TAG:   tags.info_tag = cfg_data;
                    default:        ;
                endcase
            end
            waiting <= expected_fields.size();
            fail_count <= field_errors;
        end
    end

endmodule

// ===== tb/sv/es_descriptor_parser_test.sv =====
// testbench top of the es descriptor parser: clock, reset, stimulus and verdict
module es_descriptor_parser_test
    import edp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PhaseCount = 8;
    localparam int BytesPerPhase = 165;
    localparam int StallLimit = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  field_kind;
    logic [31:0] value;
    logic [2:0]  status;
    logic        done_res;

    int fail_count;
    int waiting;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int phase_bytes;

    tags_t      tags_now;
    logic [7:0] descriptor_bytes[$];

    es_descriptor_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .field_kind(field_kind),
        .value     (value),
        .status    (status),
        .done_res  (done_res)
    );

    edp_field_check field_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .field_kind(field_kind),
        .value     (value),
        .status    (status),
        .done_res  (done_res),
        .fail_count(fail_count),
        .waiting   (waiting)
    );

    always #1 clk = ~clk;

    // receiver stalls at random
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // watchdog on cycles with no transaction
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic chance(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // field byte biased toward the extremes
    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 8'h00;
        if (roll == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // append one byte to the buffer being built
    function automatic void add_byte(input logic [7:0] b);
        descriptor_bytes = {descriptor_bytes, b};
    endfunction

    // size in 7-bit groups, sometimes padded with leading zero groups
    function automatic void push_size(input logic [27:0] v);
        int groups;
        logic [7:0] b;
        groups = (v < 28'h80) ? 1 : (v < 28'h4000) ? 2 : (v < 28'h200000) ? 3 : 4;
        groups = $urandom_range(4, groups);
        for (int g = groups - 1; g >= 0; g--) begin
            b = {g != 0, v[7*g +: 7]};
            // the fourth group ends the size whatever its top bit says
            if (g == 0 && groups == 4)
                b[7] = 1'($urandom_range(1));
            add_byte(b);
        end
    endfunction

    // one buffer, last raised on its final byte
    task automatic send_descriptor();
        foreach (descriptor_bytes[i]) begin
            while ($urandom_range(99) < idle_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            data_byte <= descriptor_bytes[i];
            last <= (i == descriptor_bytes.size() - 1);
            do
                @(posedge clk);
            while (!in_ready);
            phase_bytes++;
        end
    endtask

    initial begin
        logic [7:0]  flags_byte;
        logic [27:0] cfg_len;
        logic [27:0] info_len;
        int          cut;

        tags_now = '{es_tag: 8'd3, config_tag: 8'd4, info_tag: 8'd5};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < PhaseCount; p++) begin
            // tag registers change only while the block is idle
            if (p > 0) begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (waiting != 0);
                repeat (3) @(posedge clk);
                case (p)
                    1: tags_now = '{es_tag: 8'h00, config_tag: 8'hFF, info_tag: 8'h00};
                    2: tags_now = '{es_tag: 8'hFF, config_tag: 8'h00, info_tag: 8'hFF};
                    default: tags_now = 24'($urandom);
                endcase
                cfg_we <= 1'b1;
                cfg_index <= REG_ES_TAG;
                cfg_data <= tags_now.es_tag;
                @(posedge clk);
                cfg_index <= REG_CONFIG_TAG;
                cfg_data <= tags_now.config_tag;
                @(posedge clk);
                cfg_index <= REG_INFO_TAG;
                cfg_data <= tags_now.info_tag;
                @(posedge clk);
                cfg_we <= 1'b0;
            end

            case (p % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 68; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 68; end
                default: begin idle_pct = 20; stall_pct <= 20; end
            endcase
            phase_bytes = 0;

            // directed: wrong outer tag on the last byte, truncation after the tag,
            // url flag with trailing byte, four size groups with both optional ids
            // ending in a wrong config tag
            if (p == 0) begin
                descriptor_bytes = '{8'h00};
                send_descriptor();
                descriptor_bytes = '{tags_now.es_tag};
                send_descriptor();
                descriptor_bytes = '{tags_now.es_tag, 8'h00, 8'hFF, 8'hFF, 8'h40, 8'h00};
                send_descriptor();
                descriptor_bytes = '{tags_now.es_tag, 8'h80, 8'h80, 8'h80, 8'h80,
                                     8'h00, 8'h00, 8'hA0, 8'h12, 8'h34, 8'h56, 8'h78,
                                     8'hFF};
                send_descriptor();
            end

            while (phase_bytes < BytesPerPhase) begin
                descriptor_bytes.delete();
                if (chance(10)) begin
                    // noise buffer
                    repeat ($urandom_range(6, 1))
                        add_byte(pick_byte());
                end
                else begin
                    add_byte(chance(7) ? pick_byte() : tags_now.es_tag);
                    push_size(chance(80) ? 28'($urandom_range(200)) : 28'($urandom));
                    repeat (2) add_byte(pick_byte());
                    flags_byte = pick_byte();
                    if (!chance(7))
                        flags_byte[6] = 1'b0;
                    add_byte(flags_byte);
                    if (flags_byte[7])
                        repeat (2) add_byte(pick_byte());
                    if (flags_byte[5])
                        repeat (2) add_byte(pick_byte());
                    add_byte(chance(7) ? pick_byte() : tags_now.config_tag);
                    if (chance(45))
                        cfg_len = 28'($urandom_range(13));
                    else if (chance(90))
                        cfg_len = 28'($urandom_range(40, 14));
                    else
                        cfg_len = 28'($urandom);
                    push_size(cfg_len);
                    add_byte(pick_byte());
                    add_byte(chance(7) ? pick_byte() :
                             {AudioStreamType, 2'($urandom_range(3))});
                    repeat (11) add_byte(pick_byte());
                    if (cfg_len > CfgFieldsBytes) begin
                        add_byte(chance(7) ? pick_byte() : tags_now.info_tag);
                        if (chance(10))
                            info_len = '0;
                        else if (chance(5))
                            info_len = 28'($urandom);
                        else
                            info_len = 28'($urandom_range(12, 1));
                        push_size(info_len);
                        repeat ((info_len > 12) ? 12 : info_len)
                            add_byte(pick_byte());
                    end
                    // bytes after the parse are ignored
                    repeat ($urandom_range(2))
                        add_byte(pick_byte());
                    if (chance(12)) begin
                        cut = $urandom_range(descriptor_bytes.size(), 1);
                        while (descriptor_bytes.size() > cut)
                            void'(descriptor_bytes.pop_back());
                    end
                end
                send_descriptor();
            end
        end

        // drain
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (waiting != 0);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
